// ===== hdl/kdst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdst_pkg: shared types and constants for the key/dimension slot table
// Table geometry, operation and status codes, and the transaction payloads.
// ----------------------------------------------------------------------------
package kdst_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned DimWidth   = 10;
  localparam int unsigned SlotWidth  = 6;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned KeyWidth   = 64;

  typedef enum logic [1:0] {
    OP_PREFILL = 2'd0,
    OP_FACTOR  = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_APPENDED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_OUT_ORDER = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [KeyWidth-1:0] key;
    logic [9:0]          dim;
  } in_item_t;

  typedef struct packed {
    logic [5:0]          slot;
    logic [KeyWidth-1:0] out_key;
    logic [9:0]          out_dim;
    logic [2:0]          status;
    logic                last;
  } out_item_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [KeyWidth-1:0] key;
    logic [DimWidth-1:0] dim;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/kdst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdst_ram: entry memory
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module kdst_ram
  import kdst_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [SlotWidth-1:0] waddr_i,
  input  wire entry_t               wdata_i,
  input  wire logic [SlotWidth-1:0] raddr_i,
  output entry_t                    rdata_o
);

  entry_t mem [TableDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/key_dimension_slot_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_dimension_slot_table_top: slot table of variable keys and dimensions
// Prefill, factor search/append and sort-and-emit over one entry memory.
// ----------------------------------------------------------------------------
// One item at a time. A factor item scans the entry memory slot by slot,
// each slot in a read state and then a compare state. A finish item runs an
// insertion sort over the unordered tail, then reads every entry out, each
// entry in a read state and then a wait state, subject to output stall.
// The entry memory has one write port and one read port. No clearing pass
// is needed.
module key_dimension_slot_table_top
  import kdst_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_CHK, S_SORT_RD, S_SORT_CUR, S_SORT_CMP,
    S_SORT_PUT, S_EMIT_RD, S_EMIT_WAIT, S_OUT
  } state_e;

  state_e               state_q;
  logic [CountWidth-1:0] count_q, ord_q, idx_q, j_q;
  logic                 fseen_q;
  in_item_t             item_q;
  entry_t               cur_q;

  logic                 we;
  logic [SlotWidth-1:0] waddr, raddr;
  entry_t               wdata, rdata;

  kdst_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic out_free;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_o;

  // combinational memory control
  always_comb begin
    we    = 1'b0;
    waddr = count_q[SlotWidth-1:0];
    wdata = '{key: item_q.key, dim: item_q.dim[DimWidth-1:0]};
    raddr = idx_q[SlotWidth-1:0];
    case (state_q)
      S_IDLE: begin
        raddr = '0;
      end
      // prefill write at count_q, dimension zero
      S_OUT: begin
        we    = 1'b1;
        wdata = '{key: item_q.key, dim: '0};
      end
      S_SCAN_CHK: begin
        if (idx_q < count_q && rdata.key == item_q.key) begin
          we    = 1'b1;
          waddr = idx_q[SlotWidth-1:0];
          wdata = '{key: rdata.key, dim: item_q.dim[DimWidth-1:0]};
        end else if (!(idx_q < count_q) && count_q < CountWidth'(TableDepth)) begin
          we = 1'b1;
        end
      end
      S_SORT_CMP: begin
        raddr = SlotWidth'(j_q - 1'b1);
        if (j_q > ord_q && rdata.key > cur_q.key) begin
          we    = 1'b1;
          waddr = j_q[SlotWidth-1:0];
          wdata = rdata;
          raddr = SlotWidth'(j_q - 7'd2);
        end
      end
      S_SORT_PUT: begin
        we    = 1'b1;
        waddr = j_q[SlotWidth-1:0];
        wdata = cur_q;
      end
      S_SORT_CUR: begin
        raddr = SlotWidth'(idx_q - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ord_q       <= '0;
      fseen_q     <= 1'b0;
      out_valid_o <= 1'b0;
      idx_q       <= '0;
      j_q         <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            item_q <= in_data_i;
            idx_q  <= '0;
            case (opcode_e'(in_data_i.opcode))
              OP_PREFILL: begin
                out_valid_o <= 1'b1;
                if (fseen_q) begin
                  out_data_o <= '{slot: '0, out_key: in_data_i.key, out_dim: '0,
                                  status: ST_OUT_ORDER, last: 1'b1};
                end else if (count_q >= CountWidth'(TableDepth)) begin
                  out_data_o <= '{slot: '0, out_key: in_data_i.key, out_dim: '0,
                                  status: ST_FULL, last: 1'b1};
                end else begin
                  out_data_o <= '{slot: count_q[SlotWidth-1:0],
                                  out_key: in_data_i.key, out_dim: '0,
                                  status: ST_APPENDED, last: 1'b1};
                  state_q    <= S_OUT;
                end
              end
              OP_FACTOR: begin
                fseen_q <= 1'b1;
                state_q <= S_SCAN;
              end
              OP_FINISH: begin
                if (count_q == '0) begin
                  out_valid_o <= 1'b1;
                  out_data_o  <= '{slot: '0, out_key: '0, out_dim: '0,
                                   status: ST_EMPTY, last: 1'b1};
                  fseen_q     <= 1'b0;
                  ord_q       <= '0;
                end else begin
                  idx_q   <= ord_q + 1'b1;
                  state_q <= S_SORT_RD;
                end
              end
              default: ;
            endcase
          end
        end
        // prefill write cycle: memory written from item_q at count_q
        S_OUT: begin
          count_q <= count_q + 1'b1;
          ord_q   <= count_q + 1'b1;
          state_q <= S_IDLE;
        end
        S_SCAN: state_q <= S_SCAN_CHK;  // raddr = idx_q issued
        S_SCAN_CHK: begin
          if (idx_q < count_q && rdata.key == item_q.key) begin
            out_valid_o <= 1'b1;
            out_data_o  <= '{slot: idx_q[SlotWidth-1:0], out_key: item_q.key,
                             out_dim: 10'(item_q.dim[DimWidth-1:0]),
                             status: ST_UPDATED, last: 1'b1};
            state_q     <= S_IDLE;
          end else if (idx_q < count_q) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_SCAN;
          end else begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
            if (count_q < CountWidth'(TableDepth)) begin
              out_data_o <= '{slot: count_q[SlotWidth-1:0], out_key: item_q.key,
                              out_dim: 10'(item_q.dim[DimWidth-1:0]),
                              status: ST_APPENDED, last: 1'b1};
              count_q    <= count_q + 1'b1;
            end else begin
              out_data_o <= '{slot: '0, out_key: item_q.key,
                              out_dim: 10'(item_q.dim[DimWidth-1:0]),
                              status: ST_FULL, last: 1'b1};
            end
          end
        end
        // insertion sort: fetch element idx
        S_SORT_RD: begin
          if (idx_q >= count_q) begin
            idx_q   <= '0;
            state_q <= S_EMIT_RD;
          end else begin
            state_q <= S_SORT_CUR;
          end
        end
        S_SORT_CUR: begin
          cur_q   <= rdata;
          j_q     <= idx_q;
          state_q <= S_SORT_CMP;  // read of idx-1 issued
        end
        S_SORT_CMP: begin
          if (j_q > ord_q && rdata.key > cur_q.key) begin
            j_q <= j_q - 1'b1;  // shifted up, read of j-2 issued
          end else begin
            state_q <= S_SORT_PUT;
          end
        end
        S_SORT_PUT: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SORT_RD;
        end
        S_EMIT_RD: begin
          if (out_free) state_q <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          out_valid_o <= 1'b1;
          out_data_o  <= '{slot: idx_q[SlotWidth-1:0], out_key: rdata.key,
                           out_dim: 10'(rdata.dim), status: ST_APPENDED,
                           last: (idx_q + 1'b1 == count_q)};
          if (idx_q + 1'b1 == count_q) begin
            count_q <= '0;
            ord_q   <= '0;
            fseen_q <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_EMIT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) ord_q <= count_q)
    else $error("ordered prefix exceeds entry count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountWidth'(TableDepth)) else $error("entry count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accept while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the key/dimension slot table
// Drives prefill, factor and finish transactions with random bursts and
// output stalls, predicts every result with a behavioral table, and checks
// each result against the prediction in order.
// ----------------------------------------------------------------------------
module tb;
  import kdst_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  key_dimension_slot_table_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // behavioral copy of the table
  logic [KeyWidth-1:0] tbl_key [TableDepth];
  logic [9:0]          tbl_dim [TableDepth];
  int unsigned         tbl_count;
  int unsigned         tbl_ordered;
  bit                  tbl_factor_seen;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int unsigned n_mismatch;
  int unsigned n_checked;
  int unsigned n_sent;
  int unsigned cycle_count;
  bit          hold_sender;

  // recent keys, reused so factor items hit existing entries
  logic [KeyWidth-1:0] key_pool[$];

  function automatic out_item_t mk_result(int unsigned slot, logic [KeyWidth-1:0] k,
                                          logic [9:0] d, status_e st, bit lst);
    out_item_t r;
    r.slot    = slot[5:0];
    r.out_key = k;
    r.out_dim = d;
    r.status  = st;
    r.last    = lst;
    return r;
  endfunction

  task automatic predict_table(input in_item_t it);
    int          hit;
    int unsigned j;
    logic [KeyWidth-1:0] k;
    logic [9:0]  d;
    hit = -1;
    case (opcode_e'(it.opcode))
      OP_PREFILL: begin
        if (tbl_factor_seen) begin
          expected_results.push_back(mk_result(0, it.key, '0, ST_OUT_ORDER, 1'b1));
        end else if (tbl_count >= TableDepth) begin
          expected_results.push_back(mk_result(0, it.key, '0, ST_FULL, 1'b1));
        end else begin
          tbl_key[tbl_count] = it.key;
          tbl_dim[tbl_count] = '0;
          expected_results.push_back(mk_result(tbl_count, it.key, '0, ST_APPENDED, 1'b1));
          tbl_count++;
          tbl_ordered = tbl_count;
        end
      end
      OP_FACTOR: begin
        tbl_factor_seen = 1'b1;
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_key[i] == it.key) hit = i;
        end
        if (hit >= 0) begin
          tbl_dim[hit] = it.dim;
          expected_results.push_back(mk_result(hit, it.key, it.dim, ST_UPDATED, 1'b1));
        end else if (tbl_count >= TableDepth) begin
          expected_results.push_back(mk_result(0, it.key, it.dim, ST_FULL, 1'b1));
        end else begin
          tbl_key[tbl_count] = it.key;
          tbl_dim[tbl_count] = it.dim;
          expected_results.push_back(mk_result(tbl_count, it.key, it.dim, ST_APPENDED, 1'b1));
          tbl_count++;
        end
      end
      OP_FINISH: begin
        if (tbl_count == 0) begin
          expected_results.push_back(mk_result(0, '0, '0, ST_EMPTY, 1'b1));
        end else begin
          // insertion sort of the unordered tail
          for (int unsigned i = tbl_ordered + 1; i < tbl_count; i++) begin
            k = tbl_key[i];
            d = tbl_dim[i];
            j = i;
            while (j > tbl_ordered && tbl_key[j-1] > k) begin
              tbl_key[j] = tbl_key[j-1];
              tbl_dim[j] = tbl_dim[j-1];
              j--;
            end
            tbl_key[j] = k;
            tbl_dim[j] = d;
          end
          for (int unsigned i = 0; i < tbl_count; i++)
            expected_results.push_back(mk_result(i, tbl_key[i], tbl_dim[i], ST_APPENDED,
                                                 i + 1 == tbl_count));
        end
        tbl_count       = 0;
        tbl_ordered     = 0;
        tbl_factor_seen = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic logic [KeyWidth-1:0] rand_key();
    logic [KeyWidth-1:0] k;
    case ($urandom_range(0, 5))
      0: k = '0;
      1: k = '1;
      2: k = 64'(1) << $urandom_range(0, 63);
      default: k = {$urandom(), $urandom()};
    endcase
    return k;
  endfunction

  function automatic in_item_t mk_item(opcode_e op, logic [KeyWidth-1:0] k, logic [9:0] d);
    in_item_t it;
    it.opcode = op;
    it.key    = k;
    it.dim    = d;
    return it;
  endfunction

  // one build-up sequence: ordered prefix, factor items, finish
  task automatic queue_sequence(int unsigned max_len);
    int unsigned n_pre;
    int unsigned n_fac;
    logic [KeyWidth-1:0] k;
    key_pool.delete();
    n_pre = $urandom_range(0, max_len / 3);
    n_fac = $urandom_range(1, max_len);
    for (int i = 0; i < n_pre; i++) begin
      k = rand_key();
      key_pool.push_back(k);
      pending_items.push_back(mk_item(OP_PREFILL, k, 10'($urandom())));
    end
    for (int i = 0; i < n_fac; i++) begin
      if (key_pool.size() > 0 && $urandom_range(0, 2) == 0)
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else begin
        k = rand_key();
        key_pool.push_back(k);
      end
      pending_items.push_back(mk_item(OP_FACTOR, k, 10'($urandom())));
      // occasional late prefill or idle opcode
      if ($urandom_range(0, 19) == 0)
        pending_items.push_back(mk_item(OP_PREFILL, rand_key(), 10'($urandom())));
      if ($urandom_range(0, 29) == 0)
        pending_items.push_back(mk_item(OP_NONE, rand_key(), 10'($urandom())));
    end
    pending_items.push_back(mk_item(OP_FINISH, rand_key(), 10'($urandom())));
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  int unsigned burst_left;
  int unsigned gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_table(in_data);
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled payload
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and result checker
  int unsigned stall_phase;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 200) % 3 == 0) out_stall <= 1'b0;
      else if ((stall_phase / 200) % 3 == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 9) < 6);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: unexpected result slot=%0d key=%h dim=%0d status=%0d last=%0b",
                     out_data.slot, out_data.out_key, out_data.out_dim,
                     out_data.status, out_data.last);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          n_checked++;
          if (out_data !== e) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"ERROR: result mismatch exp slot=%0d key=%h dim=%0d st=%0d ",
                        "last=%0b got slot=%0d key=%h dim=%0d st=%0d last=%0b"},
                       e.slot, e.out_key, e.out_dim, e.status, e.last,
                       out_data.slot, out_data.out_key, out_data.out_dim,
                       out_data.status, out_data.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    n_mismatch = 0; n_checked = 0; n_sent = 0; cycle_count = 0;
    hold_sender = 1'b0;
    tbl_count = 0; tbl_ordered = 0; tbl_factor_seen = 1'b0;
    rst_n     = 1'b0;

    // directed: empty finish, extremes, update, duplicate prefill, late prefill,
    // idle opcode, sort of the unordered tail
    pending_items.push_back(mk_item(OP_FINISH, '1, '1));
    pending_items.push_back(mk_item(OP_PREFILL, '1, '1));
    pending_items.push_back(mk_item(OP_PREFILL, '0, '0));
    pending_items.push_back(mk_item(OP_PREFILL, '1, 10'h155));
    pending_items.push_back(mk_item(OP_NONE, 64'h5555_AAAA_5555_AAAA, '1));
    pending_items.push_back(mk_item(OP_FACTOR, '1, 10'h3FF));
    pending_items.push_back(mk_item(OP_FACTOR, 64'h8000_0000_0000_0000, 10'h2AA));
    pending_items.push_back(mk_item(OP_FACTOR, 64'h1, 10'h155));
    pending_items.push_back(mk_item(OP_FACTOR, 64'hAAAA_5555_AAAA_5555, 10'h0));
    pending_items.push_back(mk_item(OP_FACTOR, 64'h1, 10'h3FF));
    pending_items.push_back(mk_item(OP_PREFILL, 64'h1234, 10'h3FF));
    pending_items.push_back(mk_item(OP_FINISH, '0, '0));
    pending_items.push_back(mk_item(OP_FINISH, '0, '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0);

    // fill the table to the top, then overflow it with factor items
    for (int i = 0; i < 40; i++)
      pending_items.push_back(mk_item(OP_PREFILL, 64'(i * 3 + 7), '0));
    for (int i = 0; i < 26; i++)
      pending_items.push_back(mk_item(OP_FACTOR, 64'(1000 - i * 5) << 20, 10'($urandom())));
    pending_items.push_back(mk_item(OP_FACTOR, 64'(7), 10'h3A5));
    pending_items.push_back(mk_item(OP_PREFILL, 64'hFACE, '1));
    pending_items.push_back(mk_item(OP_FINISH, '0, '0));

    // a full table with no factor item reports full on prefill
    for (int i = 0; i < 65; i++)
      pending_items.push_back(mk_item(OP_PREFILL, {$urandom(), $urandom()}, '0));
    pending_items.push_back(mk_item(OP_FINISH, '0, '0));

    // hold off until the block has drained
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    wait (expected_results.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
    hold_sender = 1'b0;

    // random sequences, mostly short
    while (n_sent + pending_items.size() + int'(in_valid) < 420) begin
      queue_sequence(($urandom_range(0, 9) == 0) ? 70 : 12);
      if ($urandom_range(0, 5) == 0) begin
        wait (pending_items.size() == 0);
        // hold off until the block has drained
        hold_sender = 1'b1;
        wait (expected_results.size() == 0 && !in_valid);
        repeat (200) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results over %0d cycles",
             n_sent, n_checked, cycle_count);
    $display("Covered prefill, factor update/append, table overflow, late prefill, sort");
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
